// File: rtl/core/gpd_pkg.sv
package gpd_pkg;

    localparam logic [7:0] SYNC_CHAR = 8'h44;
    localparam int         PKT_LEN   = 8;
    localparam int         FILL_W    = 3;
    localparam int         GAZE_W    = 18;

    localparam logic signed [GAZE_W-1:0] GAZE_OFFSET   = 18'sd4096;
    localparam logic signed [GAZE_W-1:0] NO_LOCK_VALUE = 18'sd99999;

    // byte 0 sits in the lowest lane
    typedef logic [PKT_LEN-1:0][7:0] t_packet;

endpackage

// File: rtl/core/gpd_if.sv
interface gpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gpd_gaze_if import gpd_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [GAZE_W-1:0] gaze_x;
    logic signed [GAZE_W-1:0] gaze_y;
    logic                     lock_valid;

    modport source (output valid, output gaze_x, output gaze_y, output lock_valid,
                    input ready);
    modport sink   (input valid, input gaze_x, input gaze_y, input lock_valid,
                    output ready);
endinterface

// File: rtl/core/gaze_packet_deframer_top.sv
// A packet is queued as its last byte is taken; its result then passes the output register.
// Throughput: one byte per cycle; the front takes bytes while the packet queue has room.
// Queued results drain at one per cycle via the output register while o_gaze.ready is high.
// Reset: synchronous, active low; clears sync and packet state, fill position, queue and
// output valid. Buffer contents are not reset; every slot is written before a packet emits.
module gaze_packet_deframer_top import gpd_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gpd_rx_if.sink      i_rx,
    gpd_gaze_if.source  o_gaze
);

    logic    push_valid;
    t_packet push_data;
    logic    push_ready;
    logic    pop_valid;
    t_packet pop_data;
    logic    pop_ready;

    gpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    gpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    gpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_gaze      (o_gaze)
    );

endmodule

// File: rtl/core/gpd_front.sv
module gpd_front import gpd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gpd_rx_if.sink          i_rx,
    output logic            o_push_valid,
    output t_packet         o_push_data,
    input  logic            i_push_ready
);

    logic              r_sync_seen;
    logic              r_in_packet;
    logic [FILL_W-1:0] r_fill;
    t_packet           r_bytes;

    logic              n_sync_seen;
    logic              n_in_packet;
    logic [FILL_W-1:0] n_fill;
    t_packet           n_bytes;

    logic accept;
    logic is_sync;
    logic is_data;
    logic last_slot;

    assign i_rx.ready = i_push_ready;
    assign accept     = i_rx.valid & i_rx.ready;
    assign is_sync    = (i_rx.rx_byte == SYNC_CHAR);
    assign is_data    = accept & ~is_sync & r_in_packet;
    assign last_slot  = (r_fill == FILL_W'(PKT_LEN - 1));

    always_comb begin
        n_sync_seen = r_sync_seen;
        n_in_packet = r_in_packet;
        n_fill      = r_fill;
        n_bytes     = r_bytes;
        if (accept && is_sync) begin
            // second sync byte starts a packet
            if (r_sync_seen) begin
                n_sync_seen = 1'b0;
                n_in_packet = 1'b1;
                n_fill      = '0;
            end else begin
                n_sync_seen = 1'b1;
            end
        end else if (is_data) begin
            n_bytes[r_fill] = i_rx.rx_byte;
            // hold at the last slot until the next start
            if (!last_slot) begin
                n_fill = r_fill + FILL_W'(1);
            end
        end
    end

    assign o_push_valid = is_data & last_slot;
    assign o_push_data  = n_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_seen <= 1'b0;
            r_in_packet <= 1'b0;
            r_fill      <= '0;
        end else begin
            r_sync_seen <= n_sync_seen;
            r_in_packet <= n_in_packet;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

endmodule

// File: rtl/core/gpd_queue.sv
module gpd_queue import gpd_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    input  t_packet i_push_data,
    output logic    o_push_ready,
    output logic    o_pop_valid,
    output t_packet o_pop_data,
    input  logic    i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_packet            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/core/gpd_back.sv
module gpd_back import gpd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_pop_valid,
    input  t_packet  i_pop_data,
    output logic     o_pop_ready,
    gpd_gaze_if.source o_gaze
);

    logic                     r_valid;
    logic signed [GAZE_W-1:0] r_gaze_x;
    logic signed [GAZE_W-1:0] r_gaze_y;
    logic                     r_lock_valid;

    logic signed [GAZE_W-1:0] n_gaze_x;
    logic signed [GAZE_W-1:0] n_gaze_y;
    logic                     n_lock_valid;

    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic        load;

    assign w0 = {i_pop_data[1], i_pop_data[0]};
    assign w1 = {i_pop_data[3], i_pop_data[2]};
    assign w2 = {i_pop_data[5], i_pop_data[4]};
    assign w3 = {i_pop_data[7], i_pop_data[6]};

    always_comb begin
        n_lock_valid = |i_pop_data;
        if (n_lock_valid) begin
            n_gaze_x = $signed({{2{w0[15]}}, w0}) - $signed({{2{w2[15]}}, w2}) + GAZE_OFFSET;
            n_gaze_y = $signed({{2{w1[15]}}, w1}) - $signed({{2{w3[15]}}, w3}) + GAZE_OFFSET;
        end else begin
            n_gaze_x = NO_LOCK_VALUE;
            n_gaze_y = NO_LOCK_VALUE;
        end
    end

    // refill the output register whenever it is empty or being drained
    assign o_pop_ready = ~r_valid | o_gaze.ready;
    assign load        = i_pop_valid & o_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop_ready) begin
            r_valid <= i_pop_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_gaze_x     <= n_gaze_x;
            r_gaze_y     <= n_gaze_y;
            r_lock_valid <= n_lock_valid;
        end
    end

    assign o_gaze.valid      = r_valid;
    assign o_gaze.gaze_x     = r_gaze_x;
    assign o_gaze.gaze_y     = r_gaze_y;
    assign o_gaze.lock_valid = r_lock_valid;

endmodule

// File: test/tb_top.sv
module tb_top;
    import gpd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 550;

    typedef struct packed {
        logic signed [GAZE_W-1:0] x;
        logic signed [GAZE_W-1:0] y;
        logic                     lock;
    } t_gaze;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        int         x;
        int         y;
        bit         lock;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    gpd_rx_if   rx_ch ();
    gpd_gaze_if gaze_ch ();

    gaze_packet_deframer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_gaze  (gaze_ch)
    );

    // deframer state as seen by the predictor
    t_packet           pkt_buf   = '0;
    logic [FILL_W-1:0] fill_pos  = '0;
    bit                in_packet = 1'b0;
    bit                sync_seen = 1'b0;

    t_gaze gaze_expected[$];
    int    errors    = 0;
    int    cycles    = 0;
    int    sent_cnt  = 0;
    int    taken_cnt = 0;

    // directed bytes; typed rows carry the result read straight off the packet
    t_row dir_table [26] = '{
        '{8'h00, 1'b0, 0, 0, 1'b0},
        '{8'hFF, 1'b0, 0, 0, 1'b0},
        '{SYNC_CHAR, 1'b0, 0, 0, 1'b0},
        '{SYNC_CHAR, 1'b0, 0, 0, 1'b0},
        '{8'h00, 1'b0, 0, 0, 1'b0},
        '{8'h00, 1'b0, 0, 0, 1'b0},
        '{8'h00, 1'b0, 0, 0, 1'b0},
        '{8'h00, 1'b0, 0, 0, 1'b0},
        '{8'h00, 1'b0, 0, 0, 1'b0},
        '{8'h00, 1'b0, 0, 0, 1'b0},
        '{8'h00, 1'b0, 0, 0, 1'b0},
        '{8'h00, 1'b1, int'(NO_LOCK_VALUE), int'(NO_LOCK_VALUE), 1'b0},
        '{8'h01, 1'b0, 0, 0, 1'b0},
        '{SYNC_CHAR, 1'b0, 0, 0, 1'b0},
        '{SYNC_CHAR, 1'b0, 0, 0, 1'b0},
        '{8'hFF, 1'b0, 0, 0, 1'b0},
        '{8'h7F, 1'b0, 0, 0, 1'b0},
        '{8'h00, 1'b0, 0, 0, 1'b0},
        '{8'h80, 1'b0, 0, 0, 1'b0},
        '{8'h00, 1'b0, 0, 0, 1'b0},
        '{8'h80, 1'b0, 0, 0, 1'b0},
        '{SYNC_CHAR, 1'b0, 0, 0, 1'b0},
        '{8'hFF, 1'b0, 0, 0, 1'b0},
        '{8'h7F, 1'b1, 69631, -61439, 1'b1},
        '{SYNC_CHAR, 1'b0, 0, 0, 1'b0},
        '{8'h05, 1'b0, 0, 0, 1'b0}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic bit deframe_byte(input logic [7:0] b, output t_gaze res);
        logic signed [15:0] w0, w1, w2, w3;
        int                 gx, gy;
        res = '0;
        if (b == SYNC_CHAR) begin
            if (sync_seen) begin
                sync_seen = 1'b0;
                in_packet = 1'b1;
                fill_pos  = '0;
            end else begin
                sync_seen = 1'b1;
            end
            return 1'b0;
        end
        if (!in_packet)
            return 1'b0;
        pkt_buf[fill_pos] = b;
        // hold the position on the last slot once the packet is full
        if (fill_pos != FILL_W'(PKT_LEN - 1)) begin
            fill_pos = fill_pos + 1'b1;
            return 1'b0;
        end
        w0 = {pkt_buf[1], pkt_buf[0]};
        w1 = {pkt_buf[3], pkt_buf[2]};
        w2 = {pkt_buf[5], pkt_buf[4]};
        w3 = {pkt_buf[7], pkt_buf[6]};
        if (w0 != 0 || w1 != 0 || w2 != 0 || w3 != 0) begin
            gx = int'(w0) - int'(w2) + int'(GAZE_OFFSET);
            gy = int'(w1) - int'(w3) + int'(GAZE_OFFSET);
            res.x    = gx[GAZE_W-1:0];
            res.y    = gy[GAZE_W-1:0];
            res.lock = 1'b1;
        end else begin
            res.x    = NO_LOCK_VALUE;
            res.y    = NO_LOCK_VALUE;
            res.lock = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_data();
        logic [7:0] corner [4] = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        if ($urandom_range(0, 99) < 15)
            return corner[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        // every 64 transactions, run a stretch back to back
        gap = (sent_cnt % 64 < 12) ? 0 : $urandom_range(0, 6);
        sent_cnt++;
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
    endtask

    // result side: random stall per transaction, then compare with the oldest expectation
    initial begin
        t_gaze want;
        int    stall;
        gaze_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = (taken_cnt % 50 < 10) ? 0 : $urandom_range(0, 6);
            taken_cnt++;
            if (stall > 0) begin
                gaze_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            gaze_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!gaze_ch.valid);
            if (gaze_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d lock=%0b",
                                          gaze_ch.gaze_x, gaze_ch.gaze_y,
                                          gaze_ch.lock_valid));
            end else begin
                want = gaze_expected.pop_front();
                if (gaze_ch.gaze_x !== want.x)
                    report_mismatch($sformatf("gaze_x %0d, want %0d",
                                              gaze_ch.gaze_x, want.x));
                if (gaze_ch.gaze_y !== want.y)
                    report_mismatch($sformatf("gaze_y %0d, want %0d",
                                              gaze_ch.gaze_y, want.y));
                if (gaze_ch.lock_valid !== want.lock)
                    report_mismatch($sformatf("lock_valid %0b, want %0b",
                                              gaze_ch.lock_valid, want.lock));
            end
        end
    end

    initial begin
        logic [7:0] byte_stream[$];
        t_gaze      res;
        bit         got;
        int         kind, n, d_slot;

        i_rst_n       <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            send_byte(dir_table[i].b);
            got = deframe_byte(dir_table[i].b, res);
            if (dir_table[i].typed) begin
                res.x    = GAZE_W'(dir_table[i].x);
                res.y    = GAZE_W'(dir_table[i].y);
                res.lock = dir_table[i].lock;
                got      = 1'b1;
            end
            if (got)
                gaze_expected.push_back(res);
        end

        // mostly well-formed packets, with noise, all-zero and cut-short packets mixed in
        while (byte_stream.size() < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                byte_stream.push_back(SYNC_CHAR);
                byte_stream.push_back(SYNC_CHAR);
                d_slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : -1;
                for (int k = 0; k < PKT_LEN; k++) begin
                    if (k == d_slot)
                        byte_stream.push_back(SYNC_CHAR);
                    byte_stream.push_back(rand_data());
                end
                if ($urandom_range(0, 9) < 3) begin
                    n = $urandom_range(1, 3);
                    repeat (n) byte_stream.push_back(rand_data());
                end
            end else if (kind < 85) begin
                byte_stream.push_back(SYNC_CHAR);
                byte_stream.push_back(SYNC_CHAR);
                repeat (PKT_LEN) byte_stream.push_back(8'h00);
            end else if (kind < 95) begin
                n = $urandom_range(1, 4);
                repeat (n) byte_stream.push_back(8'($urandom_range(0, 255)));
            end else begin
                byte_stream.push_back(SYNC_CHAR);
                if ($urandom_range(0, 1) == 1) begin
                    byte_stream.push_back(SYNC_CHAR);
                    n = $urandom_range(1, PKT_LEN - 1);
                    repeat (n) byte_stream.push_back(rand_data());
                end
            end
        end

        foreach (byte_stream[i]) begin
            send_byte(byte_stream[i]);
            if (deframe_byte(byte_stream[i], res))
                gaze_expected.push_back(res);
        end
        rx_ch.valid <= 1'b0;

        while (gaze_expected.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/gpd_pkg.sv
rtl/core/gpd_if.sv
rtl/core/gpd_front.sv
rtl/core/gpd_queue.sv
rtl/core/gpd_back.sv
rtl/core/gaze_packet_deframer_top.sv
test/tb_top.sv
